// ----- design/hsv2argb_pkg.sv -----
`timescale 1ns / 1ps
// Package for the HSV to ARGB pixel converter: field types and fixed-point constants.
// No dependencies; the channel interfaces and the core take names from here.
package hsv2argb_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [14:0] t_hue;
    typedef logic [8:0]  t_frac;
    typedef logic [31:0] t_word;

    // Hue scale: one sector is 60 degrees, that is 3840 units of 1/64 degree
    localparam int HUE_MAX      = 23039;
    localparam int SECTOR_UNITS = 3840;
    localparam int FRAC_ONE     = 256;

    // floor(x / 15) for x below 4096 is (x * RECIP_15) >> RECIP_SHIFT
    localparam int RECIP_15    = 34953;
    localparam int RECIP_SHIFT = 19;

endpackage

// ----- design/hsv2argb_in_if.sv -----
`timescale 1ns / 1ps
// Input channel of the HSV to ARGB converter: valid/ready with one HSV pixel and alpha.
// Depends on hsv2argb_pkg for the field types.
interface hsv2argb_in_if;
    logic                valid;
    logic                ready;
    hsv2argb_pkg::t_byte alpha;
    hsv2argb_pkg::t_hue  hue;
    hsv2argb_pkg::t_frac saturation;
    hsv2argb_pkg::t_frac brightness;

    modport source (output valid, output alpha, output hue, output saturation,
                    output brightness, input ready);
    modport sink   (input valid, input alpha, input hue, input saturation,
                    input brightness, output ready);
endinterface

// ----- design/hsv2argb_out_if.sv -----
`timescale 1ns / 1ps
// Output channel of the HSV to ARGB converter: valid/ready with the four bytes and packed word.
// Depends on hsv2argb_pkg for the field types.
interface hsv2argb_out_if;
    logic                valid;
    logic                ready;
    hsv2argb_pkg::t_byte alpha_out;
    hsv2argb_pkg::t_byte red;
    hsv2argb_pkg::t_byte green;
    hsv2argb_pkg::t_byte blue;
    hsv2argb_pkg::t_word packed_color;

    modport source (output valid, output alpha_out, output red, output green,
                    output blue, output packed_color, input ready);
    modport sink   (input valid, input alpha_out, input red, input green,
                    input blue, input packed_color, output ready);
endinterface

// ----- design/hsv_to_argb_pixel_core.sv -----
`timescale 1ns / 1ps
// HSV to ARGB pixel converter core: seven-stage pipeline with valid bits and a common stall.
// Depends on hsv2argb_pkg, hsv2argb_in_if and hsv2argb_out_if.
//
// Usage:
//   i_pix carries one pixel per transfer: alpha, hue (1/64 degree units), saturation and
//   brightness (1/256 units, 256 is full scale). Out-of-range hue is clamped to just
//   below 360 degrees, fractions above one are clamped to one.
//   o_pix carries one result per pixel: alpha_out, red, green, blue and the packed word
//   alpha:red:green:blue. Results leave in the order the pixels came in.
// Path: each pixel passes through stage registers 1 to 6 and then the output register,
//   which drives o_pix.valid; a stall holds every stage in place.
// Throughput: one pixel per cycle while no stall holds the pipe; the slowest stage is the
//   16x20 bit ramp product, followed by a constant multiply that divides by fifteen.
// Stall: i_pix.ready is high whenever the output register is empty or being taken.
//   While the receiver holds o_pix.ready low with a result waiting, every stage holds
//   its contents, so nothing is dropped or repeated.
// Reset: i_rst_n low clears all valid bits on the next rising edge; the pipeline is
//   empty and ready for input right after.
module hsv_to_argb_pixel_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hsv2argb_in_if.sink           i_pix,
    hsv2argb_out_if.source        o_pix
);

    // Hue sector, named after the two primaries/secondaries it runs between
    typedef enum logic [2:0] {
        SEC_RED_YELLOW     = 3'd0,
        SEC_YELLOW_GREEN   = 3'd1,
        SEC_GREEN_CYAN     = 3'd2,
        SEC_CYAN_BLUE      = 3'd3,
        SEC_BLUE_MAGENTA   = 3'd4,
        SEC_MAGENTA_RED    = 3'd5
    } t_sector;

    localparam int SU = hsv2argb_pkg::SECTOR_UNITS;

    // Pipeline advance: the whole pipe moves unless a finished result is held up
    logic w_adv;

    // Valid bits, one per stage, plus the output register
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r_out_vld;

    // Stage 1: clamped inputs, sector, P = 255 * v
    hsv2argb_pkg::t_byte r1_alpha;
    t_sector             r1_sector;
    hsv2argb_pkg::t_hue  r1_h;
    hsv2argb_pkg::t_frac r1_s;
    hsv2argb_pkg::t_frac r1_oms;
    logic [15:0]         r1_p;

    // Stage 2: ramp and floor product
    hsv2argb_pkg::t_byte r2_alpha;
    t_sector             r2_sector;
    hsv2argb_pkg::t_frac r2_s;
    hsv2argb_pkg::t_frac r2_oms;
    logic [15:0]         r2_p;
    logic [11:0]         r2_ramp;
    logic [23:0]         r2_nprod;

    // Stage 3: saturation times ramp, floor byte
    hsv2argb_pkg::t_byte r3_alpha;
    t_sector             r3_sector;
    hsv2argb_pkg::t_frac r3_oms;
    logic [15:0]         r3_p;
    logic [19:0]         r3_sr;
    hsv2argb_pkg::t_byte r3_n;

    // Stage 4: ramp weight q
    hsv2argb_pkg::t_byte r4_alpha;
    t_sector             r4_sector;
    logic [15:0]         r4_p;
    logic [19:0]         r4_q;
    hsv2argb_pkg::t_byte r4_n;

    // Stage 5: ramp product scaled down by 2^24
    hsv2argb_pkg::t_byte r5_alpha;
    t_sector             r5_sector;
    hsv2argb_pkg::t_byte r5_m;
    hsv2argb_pkg::t_byte r5_n;
    logic [11:0]         r5_zhi;

    // Stage 6: divide by fifteen through the reciprocal
    hsv2argb_pkg::t_byte r6_alpha;
    t_sector             r6_sector;
    hsv2argb_pkg::t_byte r6_m;
    hsv2argb_pkg::t_byte r6_n;
    logic [27:0]         r6_rec;

    // Output register
    hsv2argb_pkg::t_byte r_out_alpha;
    hsv2argb_pkg::t_byte r_out_red;
    hsv2argb_pkg::t_byte r_out_green;
    hsv2argb_pkg::t_byte r_out_blue;

    // Combinational terms
    hsv2argb_pkg::t_hue  w_h;
    hsv2argb_pkg::t_frac w_s;
    hsv2argb_pkg::t_frac w_v;
    t_sector             w_sector;
    logic [16:0]         w_p17;
    logic [12:0]         w_t;
    logic [11:0]         w_dist;
    logic [20:0]         w_q21;
    logic [35:0]         w_zprod;
    hsv2argb_pkg::t_byte w_z;
    hsv2argb_pkg::t_byte n_red;
    hsv2argb_pkg::t_byte n_green;
    hsv2argb_pkg::t_byte n_blue;

    assign w_adv       = !r_out_vld || o_pix.ready;
    assign i_pix.ready = w_adv;

    // ---- Stage 1 logic: clamp, find the sector, form 255 * v ----
    always_comb begin
        w_h = (i_pix.hue > 15'(hsv2argb_pkg::HUE_MAX)) ? 15'(hsv2argb_pkg::HUE_MAX)
                                                      : i_pix.hue;
        w_s = (i_pix.saturation > 9'(hsv2argb_pkg::FRAC_ONE)) ? 9'(hsv2argb_pkg::FRAC_ONE)
                                                              : i_pix.saturation;
        w_v = (i_pix.brightness > 9'(hsv2argb_pkg::FRAC_ONE)) ? 9'(hsv2argb_pkg::FRAC_ONE)
                                                              : i_pix.brightness;
        if (w_h < 15'(SU)) begin
            w_sector = SEC_RED_YELLOW;
        end else if (w_h < 15'(2 * SU)) begin
            w_sector = SEC_YELLOW_GREEN;
        end else if (w_h < 15'(3 * SU)) begin
            w_sector = SEC_GREEN_CYAN;
        end else if (w_h < 15'(4 * SU)) begin
            w_sector = SEC_CYAN_BLUE;
        end else if (w_h < 15'(5 * SU)) begin
            w_sector = SEC_BLUE_MAGENTA;
        end else begin
            w_sector = SEC_MAGENTA_RED;
        end
        w_p17 = {w_v, 8'b0} - 17'(w_v);
    end

    // ---- Stage 2 logic: position inside the double sector, distance to its centre ----
    always_comb begin
        case (r1_sector)
            SEC_RED_YELLOW, SEC_YELLOW_GREEN: w_t = 13'(r1_h);
            SEC_GREEN_CYAN, SEC_CYAN_BLUE:    w_t = 13'(r1_h - 15'(2 * SU));
            SEC_BLUE_MAGENTA, SEC_MAGENTA_RED: w_t = 13'(r1_h - 15'(4 * SU));
            default:                          w_t = 13'(r1_h);
        endcase
        w_dist = (w_t > 13'(SU)) ? 12'(w_t - 13'(SU)) : 12'(13'(SU) - w_t);
    end

    // ---- Stage 4 logic: q = 3840 * (256 - s) + s * ramp ----
    assign w_q21 = {r3_oms, 12'b0} - 21'({r3_oms, 8'b0}) + 21'(r3_sr);

    // ---- Stage 5 logic: ramp product ----
    assign w_zprod = 36'(r4_p) * 36'(r4_q);

    // ---- Output stage: route top, floor and ramp by sector ----
    assign w_z = r6_rec[hsv2argb_pkg::RECIP_SHIFT +: 8];

    always_comb begin
        case (r6_sector)
            SEC_RED_YELLOW: begin
                n_red = r6_m; n_green = w_z;  n_blue = r6_n;
            end
            SEC_YELLOW_GREEN: begin
                n_red = w_z;  n_green = r6_m; n_blue = r6_n;
            end
            SEC_GREEN_CYAN: begin
                n_red = r6_n; n_green = r6_m; n_blue = w_z;
            end
            SEC_CYAN_BLUE: begin
                n_red = r6_n; n_green = w_z;  n_blue = r6_m;
            end
            SEC_BLUE_MAGENTA: begin
                n_red = w_z;  n_green = r6_n; n_blue = r6_m;
            end
            default: begin
                n_red = r6_m; n_green = r6_n; n_blue = w_z;
            end
        endcase
    end

    // Valid bits: clear on reset, advance together, hold on stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r6_vld    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld    <= i_pix.valid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r4_vld    <= r3_vld;
            r5_vld    <= r4_vld;
            r6_vld    <= r5_vld;
            r_out_vld <= r6_vld;
        end
    end

    // Payload: no reset, advance with the valid bits
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_alpha    <= i_pix.alpha;
            r1_sector   <= w_sector;
            r1_h        <= w_h;
            r1_s        <= w_s;
            r1_oms      <= 9'(hsv2argb_pkg::FRAC_ONE) - w_s;
            r1_p        <= w_p17[15:0];

            r2_alpha    <= r1_alpha;
            r2_sector   <= r1_sector;
            r2_s        <= r1_s;
            r2_oms      <= r1_oms;
            r2_p        <= r1_p;
            r2_ramp     <= 12'(SU) - w_dist;
            r2_nprod    <= 24'(25'(r1_p) * 25'(r1_oms));

            r3_alpha    <= r2_alpha;
            r3_sector   <= r2_sector;
            r3_oms      <= r2_oms;
            r3_p        <= r2_p;
            r3_sr       <= 20'(21'(r2_s) * 21'(r2_ramp));
            r3_n        <= r2_nprod[23:16];

            r4_alpha    <= r3_alpha;
            r4_sector   <= r3_sector;
            r4_p        <= r3_p;
            r4_q        <= w_q21[19:0];
            r4_n        <= r3_n;

            r5_alpha    <= r4_alpha;
            r5_sector   <= r4_sector;
            r5_m        <= r4_p[15:8];
            r5_n        <= r4_n;
            r5_zhi      <= w_zprod[35:24];

            r6_alpha    <= r5_alpha;
            r6_sector   <= r5_sector;
            r6_m        <= r5_m;
            r6_n        <= r5_n;
            r6_rec      <= 28'(r5_zhi) * 28'(hsv2argb_pkg::RECIP_15);

            r_out_alpha <= r6_alpha;
            r_out_red   <= n_red;
            r_out_green <= n_green;
            r_out_blue  <= n_blue;
        end
    end

    assign o_pix.valid        = r_out_vld;
    assign o_pix.alpha_out    = r_out_alpha;
    assign o_pix.red          = r_out_red;
    assign o_pix.green        = r_out_green;
    assign o_pix.blue         = r_out_blue;
    assign o_pix.packed_color = {r_out_alpha, r_out_red, r_out_green, r_out_blue};

    // Reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_pix.valid)
        else $error("output valid after reset");

    // A stall freezes every valid bit
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable({r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r_out_vld}))
        else $error("pipeline moved during a stall");

    // A finished item in the last stage reaches the output register when the pipe moves
    a_last_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r6_vld) |=> o_pix.valid)
        else $error("item lost between last stage and output");

    // The ramp always lies between the floor and the top level
    a_ramp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r6_vld |-> (r6_n <= r6_m && w_z >= r6_n && w_z <= r6_m))
        else $error("ramp component outside floor..top");

endmodule

// ----- tb/tb_hsv_to_argb_pixel_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for hsv_to_argb_pixel_core: random and directed HSV pixels in,
// ARGB results checked in order against an internal fixed-point HSV to RGB calculation.
// Depends on hsv2argb_pkg, hsv2argb_in_if, hsv2argb_out_if and the core itself.
module tb_hsv_to_argb_pixel_core;

    // Run shape
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int PIXEL_TOTAL    = 1950;
    localparam int TAIL_PIXELS    = 150;     // no idling on either side for the last pixels
    localparam int HOLDOFF_AT     = 600;     // transfers before the long receiver hold-off
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 20;      // pipeline is seven deep, allow a margin
    localparam int CYCLE_LIMIT    = 250000;
    localparam int REPORT_LIMIT   = 10;

    // Fixed-point scale, taken from the package so the predictor uses the block's units
    localparam longint unsigned HUE_LIM    = hsv2argb_pkg::HUE_MAX;
    localparam longint unsigned SECTOR     = hsv2argb_pkg::SECTOR_UNITS;
    localparam longint unsigned UNITY      = hsv2argb_pkg::FRAC_ONE;
    localparam longint unsigned FULL_LEVEL = 255;

    typedef struct packed {
        hsv2argb_pkg::t_byte alpha;
        hsv2argb_pkg::t_hue  hue;
        hsv2argb_pkg::t_frac saturation;
        hsv2argb_pkg::t_frac brightness;
    } hsv_pixel_t;

    typedef struct packed {
        hsv2argb_pkg::t_byte alpha;
        hsv2argb_pkg::t_byte red;
        hsv2argb_pkg::t_byte green;
        hsv2argb_pkg::t_byte blue;
        hsv2argb_pkg::t_word packed_color;
    } argb_result_t;

    logic i_clk;
    logic i_rst_n;

    hsv2argb_in_if  pix_in ();
    hsv2argb_out_if pix_out ();

    hsv_to_argb_pixel_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    // Pixels waiting to be offered, and the colours still owed by the block
    hsv_pixel_t   pixel_backlog[$];
    argb_result_t argb_expected[$];

    hsv_pixel_t offered_pix;
    logic       offering     = 1'b0;
    int         send_gap     = 0;
    int         sink_stall   = 0;
    int         pixels_sent  = 0;
    logic       tail_phase   = 1'b0;
    int         holdoff_left = 0;
    logic       holdoff_done = 1'b0;
    int         error_count  = 0;
    int         cycle_count  = 0;

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // Floor of the exact HSV to RGB value: clamp the inputs, find the hue sector and the
    // distance into the rising or falling ramp, form every level over one common
    // denominator and divide once.
    function automatic argb_result_t predict_argb(hsv_pixel_t px);
        longint unsigned hue_c, sat_c, val_c;
        longint unsigned sector_idx, phase, centre_gap, ramp, denom;
        longint unsigned top_lvl, floor_lvl, ramp_lvl;
        argb_result_t    res;
        hue_c = 64'(px.hue);
        sat_c = 64'(px.saturation);
        val_c = 64'(px.brightness);
        if (hue_c > HUE_LIM) hue_c = HUE_LIM;
        if (sat_c > UNITY) sat_c = UNITY;
        if (val_c > UNITY) val_c = UNITY;
        sector_idx = hue_c / SECTOR;
        phase      = hue_c % (2 * SECTOR);
        centre_gap = (phase > SECTOR) ? phase - SECTOR : SECTOR - phase;
        ramp       = SECTOR - centre_gap;
        denom      = UNITY * UNITY * SECTOR;
        top_lvl    = (FULL_LEVEL * val_c * UNITY * SECTOR) / denom;
        floor_lvl  = (FULL_LEVEL * val_c * (UNITY - sat_c) * SECTOR) / denom;
        ramp_lvl   = (FULL_LEVEL * val_c * (UNITY - sat_c) * SECTOR
                      + FULL_LEVEL * val_c * sat_c * ramp) / denom;
        if (top_lvl > FULL_LEVEL) top_lvl = FULL_LEVEL;
        if (floor_lvl > FULL_LEVEL) floor_lvl = FULL_LEVEL;
        if (ramp_lvl > FULL_LEVEL) ramp_lvl = FULL_LEVEL;
        res.alpha = px.alpha;
        case (sector_idx)
            0: begin
                res.red = top_lvl[7:0];   res.green = ramp_lvl[7:0];  res.blue = floor_lvl[7:0];
            end
            1: begin
                res.red = ramp_lvl[7:0];  res.green = top_lvl[7:0];   res.blue = floor_lvl[7:0];
            end
            2: begin
                res.red = floor_lvl[7:0]; res.green = top_lvl[7:0];   res.blue = ramp_lvl[7:0];
            end
            3: begin
                res.red = floor_lvl[7:0]; res.green = ramp_lvl[7:0];  res.blue = top_lvl[7:0];
            end
            4: begin
                res.red = ramp_lvl[7:0];  res.green = floor_lvl[7:0]; res.blue = top_lvl[7:0];
            end
            default: begin
                res.red = top_lvl[7:0];   res.green = floor_lvl[7:0]; res.blue = ramp_lvl[7:0];
            end
        endcase
        res.packed_color = {res.alpha, res.red, res.green, res.blue};
        return res;
    endfunction

    task automatic queue_pixel(input int a, input int h, input int s, input int v);
        hsv_pixel_t px;
        px.alpha      = a[7:0];
        px.hue        = h[14:0];
        px.saturation = s[8:0];
        px.brightness = v[8:0];
        pixel_backlog.push_back(px);
    endtask

    // Mostly legal fractions, with the unity corners and the out-of-range codes mixed in
    function automatic hsv2argb_pkg::t_frac random_frac();
        int pick;
        int corner;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 9'($urandom_range(0, 511));
        if (pick == 1) begin
            corner = $urandom_range(0, 3);
            case (corner)
                0:       return 9'd0;
                1:       return 9'd1;
                2:       return 9'd255;
                default: return 9'd256;
            endcase
        end
        return 9'($urandom_range(0, 256));
    endfunction

    // Mostly legal hues, some hugging a sector boundary, some above 360 degrees
    function automatic hsv2argb_pkg::t_hue random_hue();
        int pick;
        int h;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 15'($urandom_range(0, 32767));
        if (pick <= 2) begin
            h = $urandom_range(0, 6) * int'(SECTOR) + $urandom_range(0, 4) - 2;
            if (h < 0) h = 0;
            return h[14:0];
        end
        return 15'($urandom_range(0, int'(HUE_LIM)));
    endfunction

    // Sender: hold a pixel on the channel until it is taken, idle only between transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
        end else begin
            if (pix_in.valid && pix_in.ready) begin
                argb_expected.push_back(predict_argb(offered_pix));
                pixels_sent <= pixels_sent + 1;
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_gap != 0) begin
                    send_gap = send_gap - 1;
                end else if (pixel_backlog.size() != 0) begin
                    if (!tail_phase && $urandom_range(0, 7) == 0) begin
                        // idle instead of offering, and draw a random send_gap
                        send_gap = $urandom_range(0, 9);
                    end else begin
                        offered_pix = pixel_backlog.pop_front();
                        offering = 1'b1;
                        pix_in.alpha      <= offered_pix.alpha;
                        pix_in.hue        <= offered_pix.hue;
                        pix_in.saturation <= offered_pix.saturation;
                        pix_in.brightness <= offered_pix.brightness;
                    end
                end
            end
            pix_in.valid <= offering;
            tail_phase   <= (pixel_backlog.size() < TAIL_PIXELS);
        end
    end

    // Long receiver hold-off, once, while the sender keeps offering: fill the pipeline
    // and force it to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            holdoff_left <= 0;
        end else if (!holdoff_done && pixels_sent >= HOLDOFF_AT) begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_done <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
        end
    end

    // Receiver: check each transfer against the oldest colour owed, stall in random bursts
    always @(posedge i_clk) begin
        argb_result_t want;
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
        end else begin
            if (pix_out.valid && pix_out.ready) begin
                if (argb_expected.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= REPORT_LIMIT)
                        $display("Unrequested result at cycle %0d: packed %08h",
                                 cycle_count, pix_out.packed_color);
                end else begin
                    want = argb_expected.pop_front();
                    if (pix_out.alpha_out !== want.alpha || pix_out.red !== want.red ||
                        pix_out.green !== want.green || pix_out.blue !== want.blue ||
                        pix_out.packed_color !== want.packed_color) begin
                        error_count = error_count + 1;
                        if (error_count <= REPORT_LIMIT) begin
                            $write(
                                "Mismatch at cycle %0d: expected a=%02h r=%02h g=%02h ",
                                cycle_count, want.alpha, want.red, want.green);
                            $write("b=%02h word=%08h, got a=%02h r=%02h ", want.blue,
                                   want.packed_color, pix_out.alpha_out, pix_out.red);
                            $display("g=%02h b=%02h word=%08h", pix_out.green,
                                     pix_out.blue, pix_out.packed_color);
                        end
                    end
                end
            end
            if (sink_stall != 0)
                sink_stall = sink_stall - 1;
            else if (!tail_phase && $urandom_range(0, 7) == 0)
                sink_stall = $urandom_range(1, 10);
            pix_out.ready <= (sink_stall == 0) && (holdoff_left == 0);
        end
    end

    // Watchdog: drop out with a failure if the run stalls for good
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;

        // Directed pixels: each sector and its edges, grey, black, clamping of hue, saturation and brightness
        queue_pixel(0,     0,     256, 256);
        queue_pixel(255,   3839,  256, 256);
        queue_pixel('hA5,  3840,  256, 256);
        queue_pixel('h5A,  7679,  128, 200);
        queue_pixel(1,     7680,  256, 256);
        queue_pixel(2,     11519, 200, 256);
        queue_pixel(3,     11520, 256, 256);
        queue_pixel(4,     15360, 256, 128);
        queue_pixel(5,     19200, 256, 256);
        queue_pixel(6,     int'(HUE_LIM), 256, 256);
        queue_pixel(7,     int'(HUE_LIM) + 1, 256, 256);    // hue at 360 degrees, out of range
        queue_pixel(8,     32767, 100, 180);
        queue_pixel(9,     1920,  0,   256);                 // no saturation: grey
        queue_pixel(10,    5000,  256, 0);                   // black
        queue_pixel(11,    5000,  257, 256);                 // saturation above one
        queue_pixel(12,    9000,  511, 256);
        queue_pixel(13,    13000, 128, 257);                 // brightness above one
        queue_pixel(14,    17000, 128, 511);
        queue_pixel(15,    21000, 511, 511);
        queue_pixel(16,    0,     0,   0);
        queue_pixel(255,   1,     1,   1);
        queue_pixel(128,   1920,  255, 255);
        queue_pixel(64,    5760,  1,   256);

        while (pixel_backlog.size() < PIXEL_TOTAL)
            queue_pixel(int'($urandom_range(0, 255)), int'(random_hue()),
                        int'(random_frac()), int'(random_frac()));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Let every pixel go out and every colour come back, then allow the pipeline to settle
        do @(negedge i_clk);
        while (pixel_backlog.size() != 0 || offering || argb_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0 && argb_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- hsv_to_argb_pixel_core.f -----
design/hsv2argb_pkg.sv
design/hsv2argb_in_if.sv
design/hsv2argb_out_if.sv
design/hsv_to_argb_pixel_core.sv
tb/tb_hsv_to_argb_pixel_core.sv
